// File: rtl/vmd_pkg.sv
// Shared types, constants and the cosine table builder for the vibrato delay.
package vmd_pkg;

  localparam int SMP_W       = 16;
  localparam int MAX_PERIOD  = 4096;
  localparam int PTR_W       = 12;
  localparam int LEN_W       = 13;
  localparam int DEPTH_W     = 20;
  localparam int STEP_W      = 32;
  localparam int COS_ENTRIES = 1024;
  localparam int COS_AW      = 10;
  localparam int COS_W       = 17;
  localparam int DELAY_W     = 22;
  localparam int FRAC_W      = 8;
  localparam int PROD_W      = DEPTH_W + COS_W;
  localparam int APB_AW      = 4;
  localparam int APB_DW      = 32;

  localparam logic [1:0] REG_PERIOD_LENGTH = 2'd0;
  localparam logic [1:0] REG_DEPTH         = 2'd1;
  localparam logic [1:0] REG_PHASE_STEP    = 2'd2;

  localparam logic [LEN_W-1:0]   PERIOD_RESET = 13'd4096;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET  = 20'd0;
  localparam logic [STEP_W-1:0]  STEP_RESET   = 32'd1048576;

  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  typedef struct packed {
    logic [LEN_W-1:0]   period_length;
    logic [DEPTH_W-1:0] depth;
    logic [STEP_W-1:0]  phase_step;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic mul;
    logic addr;
    logic rd_new;
    logic rd_old;
    logic mix;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_busy;
  } sts_t;

  typedef logic [COS_ENTRIES-1:0][COS_W-1:0] cos_rom_t;

  // Builds 1 - cos over one full period as 2*sin^2, with the sine taken from a
  // truncated Taylor series in Q2.30 and quarter-wave folding.
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t    rom;
    logic [63:0] j;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] v;
    logic [63:0] s;
    logic [63:0] s2;
    for (int i = 0; i < COS_ENTRIES; i++) begin
      j = 64'(i);
      if (2 * j > 64'(COS_ENTRIES)) begin
        j = 64'(COS_ENTRIES) - j;
      end
      t  = (PI_Q30 * j) / COS_ENTRIES;
      t2 = (t * t) >> 30;
      v  = Q30_ONE - ((t2 * Q30_ONE) >> 30) / 64'd110;
      v  = Q30_ONE - ((t2 * v) >> 30) / 64'd72;
      v  = Q30_ONE - ((t2 * v) >> 30) / 64'd42;
      v  = Q30_ONE - ((t2 * v) >> 30) / 64'd20;
      v  = Q30_ONE - ((t2 * v) >> 30) / 64'd6;
      s  = (t * v) >> 30;
      if (s > Q30_ONE) begin
        s = Q30_ONE;
      end
      s2 = (s * s) >> 30;
      rom[i] = COS_W'((s2 + 64'd8192) >> 14);
    end
    return rom;
  endfunction

endpackage

// File: rtl/vibrato_modulated_delay_unit.sv
// Top level of the vibrato modulated delay line.
//
//   Channel   Direction  Handshake               Payload
//   input     in         in_valid_i/in_ready_o   sample_in_i (Q1.15)
//   output    out        out_valid_o/out_ready_i sample_out_o (Q1.15)
//   config    in         APB psel/penable/pwrite paddr, pwdata, prdata
//
// A word passes through six steps: accept with store write and cosine lookup, the
// depth multiply, read-pointer arithmetic, two reads of the single-port delay
// store and the interpolation into the output register.
// After reset the 4096-entry delay store is cleared entry by entry, during
// which in_ready_o stays low; configuration writes are taken throughout.
// A result waits in the output register while the next word is accepted and
// worked on; the last step stalls only if that register is still full.
module vibrato_modulated_delay_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vmd_pkg::APB_AW-1:0]        paddr,
  input  logic [vmd_pkg::APB_DW-1:0]        pwdata,
  output logic [vmd_pkg::APB_DW-1:0]        prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [vmd_pkg::SMP_W-1:0]  sample_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [vmd_pkg::SMP_W-1:0]  sample_out_o
);
  import vmd_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  vmd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  vmd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vmd_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .sample_in_i  (sample_in_i),
    .sample_out_o (sample_out_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

endmodule

// File: rtl/vmd_regs.sv
// APB-style configuration registers of the vibrato delay.
module vmd_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [vmd_pkg::APB_AW-1:0] paddr,
  input  logic [vmd_pkg::APB_DW-1:0] pwdata,
  output logic [vmd_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  output vmd_pkg::cfg_t             cfg_o
);
  import vmd_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_length <= PERIOD_RESET;
      cfg_q.depth         <= DEPTH_RESET;
      cfg_q.phase_step    <= STEP_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PERIOD_LENGTH: cfg_q.period_length <= pwdata[LEN_W-1:0];
        REG_DEPTH:         cfg_q.depth         <= pwdata[DEPTH_W-1:0];
        REG_PHASE_STEP:    cfg_q.phase_step    <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PERIOD_LENGTH: prdata = APB_DW'(cfg_q.period_length);
      REG_DEPTH:         prdata = APB_DW'(cfg_q.depth);
      REG_PHASE_STEP:    prdata = APB_DW'(cfg_q.phase_step);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/vmd_ctrl.sv
// Sequencing state machine of the vibrato delay.
module vmd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  vmd_pkg::sts_t sts_i,
  output vmd_pkg::cmd_t cmd_o
);
  import vmd_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_ADDR  = 3'd3;
  localparam logic [2:0] ST_RDN   = 3'd4;
  localparam logic [2:0] ST_RDO   = 3'd5;
  localparam logic [2:0] ST_MIX   = 3'd6;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ADDR;
      end
      ST_ADDR: begin
        cmd_o.addr = 1'b1;
        state_d    = ST_RDN;
      end
      ST_RDN: begin
        cmd_o.rd_new = 1'b1;
        state_d      = ST_RDO;
      end
      ST_RDO: begin
        cmd_o.rd_old = 1'b1;
        state_d      = ST_MIX;
      end
      ST_MIX: begin
        // The previous word must have left the output register first.
        if (!sts_i.out_busy) begin
          cmd_o.mix = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/vmd_dp.sv
// Datapath of the vibrato delay: delay store, cosine table, LFO and interpolator.
module vmd_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  vmd_pkg::cfg_t                     cfg_i,
  input  vmd_pkg::cmd_t                     cmd_i,
  output vmd_pkg::sts_t                     sts_o,
  input  logic signed [vmd_pkg::SMP_W-1:0]  sample_in_i,
  output logic signed [vmd_pkg::SMP_W-1:0]  sample_out_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i
);
  import vmd_pkg::*;

  localparam cos_rom_t COS_ROM = build_cos_rom();

  logic signed [SMP_W-1:0] store [MAX_PERIOD];

  logic [PTR_W-1:0]        clr_addr_q;
  logic [PTR_W-1:0]        widx_q;
  logic [STEP_W-1:0]       phase_q;
  logic [COS_W-1:0]        rom_q;
  logic [DELAY_W-1:0]      delay_q;
  logic [PTR_W-1:0]        newer_q;
  logic [PTR_W-1:0]        older_q;
  logic [FRAC_W-1:0]       frac_q;
  logic signed [SMP_W-1:0] rdata_q;
  logic signed [SMP_W-1:0] newer_data_q;
  logic signed [SMP_W-1:0] out_q;
  logic                    out_valid_q;

  logic [LEN_W-1:0]        len;
  logic [PTR_W-1:0]        w_eff;
  logic [LEN_W-1:0]        widx_inc;
  logic [PROD_W-1:0]       prod;
  logic [LEN_W+FRAC_W-1:0] max_delay;
  logic [DELAY_W-1:0]      delay_sat;
  logic [PTR_W-1:0]        d_int;
  logic [LEN_W:0]          pos_sum;
  logic [LEN_W:0]          pos_wrap;
  logic [PTR_W-1:0]        raddr;
  logic [FRAC_W:0]         wt_new;
  logic signed [26:0]      acc;
  logic signed [18:0]      mixed;
  logic signed [SMP_W-1:0] mixed_sat;

  // Store length in use: a zero period acts as one, a long one as the store size.
  always_comb begin
    if (cfg_i.period_length == '0) begin
      len = LEN_W'(1);
    end else if (cfg_i.period_length > LEN_W'(MAX_PERIOD)) begin
      len = LEN_W'(MAX_PERIOD);
    end else begin
      len = cfg_i.period_length;
    end
  end

  assign w_eff    = ({1'b0, widx_q} >= len) ? '0 : widx_q;
  assign widx_inc = {1'b0, widx_q} + LEN_W'(1);

  assign prod      = cfg_i.depth * rom_q;
  assign max_delay = {len - LEN_W'(1), FRAC_W'(0)};
  assign delay_sat = (delay_q > DELAY_W'(max_delay)) ? DELAY_W'(max_delay) : delay_q;
  assign d_int     = delay_sat[FRAC_W +: PTR_W];

  // The integer delay never exceeds len - 1, so one conditional subtract wraps.
  assign pos_sum  = {2'b0, widx_q} + {1'b0, len} - {2'b0, d_int};
  assign pos_wrap = (pos_sum >= {1'b0, len}) ? pos_sum - {1'b0, len} : pos_sum;

  assign raddr = cmd_i.rd_old ? older_q : newer_q;

  assign wt_new = (FRAC_W + 1)'(256) - {1'b0, frac_q};
  assign acc    = 27'(newer_data_q * $signed({1'b0, wt_new}))
                + 27'(rdata_q * $signed({2'b0, frac_q}))
                + 27'sd128;
  assign mixed  = 19'(acc >>> FRAC_W);

  always_comb begin
    if (mixed > 19'sd32767) begin
      mixed_sat = 16'sh7fff;
    end else if (mixed < -19'sd32768) begin
      mixed_sat = 16'sh8000;
    end else begin
      mixed_sat = mixed[SMP_W-1:0];
    end
  end

  // Delay store: the clearing sweep after reset, then one sample write per word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      store[clr_addr_q] <= '0;
    end else if (cmd_i.accept) begin
      store[w_eff] <= sample_in_i;
    end
  end

  // The read register keeps the older neighbour while the mix step waits.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_new || cmd_i.rd_old) begin
      rdata_q <= store[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      widx_q      <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + PTR_W'(1);
      end
      if (cmd_i.accept) begin
        widx_q  <= w_eff;
        phase_q <= phase_q + cfg_i.phase_step;
      end else if (cmd_i.mix) begin
        widx_q <= (widx_inc >= len) ? '0 : widx_inc[PTR_W-1:0];
      end
      if (cmd_i.mix) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rom_q <= COS_ROM[phase_q[STEP_W-1 -: COS_AW]];
    end
    if (cmd_i.mul) begin
      delay_q <= prod[PROD_W-1:15];
    end
    if (cmd_i.addr) begin
      newer_q <= pos_wrap[PTR_W-1:0];
      frac_q  <= delay_sat[FRAC_W-1:0];
    end
    if (cmd_i.rd_new) begin
      older_q <= (newer_q == '0) ? PTR_W'(len - LEN_W'(1)) : newer_q - PTR_W'(1);
    end
    if (cmd_i.rd_old) begin
      newer_data_q <= rdata_q;
    end
    if (cmd_i.mix) begin
      out_q <= mixed_sat;
    end
  end

  assign sts_o.clear_last = (clr_addr_q == PTR_W'(MAX_PERIOD - 1));
  assign sts_o.out_busy   = out_valid_q & ~out_ready_i;

  assign sample_out_o = out_q;
  assign out_valid_o  = out_valid_q;

endmodule

// File: tb/tb_vibrato_modulated_delay_unit.sv
// Self-checking testbench for the vibrato modulated delay unit.
module tb_vibrato_modulated_delay_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned PHASE_WORDS = 120;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] PI_IN_Q30   = 64'd3373259426;
  // Taylor divisors for the sine polynomial, innermost first.
  localparam logic [4:0][6:0] TAYLOR_DIV = {7'd6, 7'd20, 7'd42, 7'd72, 7'd110};

  logic                                clk_i       = 1'b0;
  logic                                rst_ni      = 1'b0;
  logic                                psel        = 1'b0;
  logic                                penable     = 1'b0;
  logic                                pwrite      = 1'b0;
  logic [vmd_pkg::APB_AW-1:0]          paddr       = '0;
  logic [vmd_pkg::APB_DW-1:0]          pwdata      = '0;
  logic [vmd_pkg::APB_DW-1:0]          prdata;
  logic                                pready;
  logic                                in_valid_i  = 1'b0;
  logic                                in_ready_o;
  logic signed [vmd_pkg::SMP_W-1:0]    sample_in_i = '0;
  logic                                out_valid_o;
  logic                                out_ready_i = 1'b0;
  logic signed [vmd_pkg::SMP_W-1:0]    sample_out_o;

  // Predictor state: its own copy of the store, pointers and registers.
  logic signed [vmd_pkg::SMP_W-1:0] delay_copy [0:vmd_pkg::MAX_PERIOD-1];
  logic [vmd_pkg::COS_W-1:0]        versine_q15 [0:vmd_pkg::COS_ENTRIES-1];
  logic [vmd_pkg::LEN_W-1:0]        write_ptr;
  logic [vmd_pkg::STEP_W-1:0]       lfo_acc;
  vmd_pkg::cfg_t                    model_cfg;

  logic signed [vmd_pkg::SMP_W-1:0] pending_words [$];
  logic signed [vmd_pkg::SMP_W-1:0] expected_samples [$];
  int unsigned                      send_idle_pct = 30;
  int unsigned                      recv_idle_pct = 54;
  int unsigned                      mismatch_count = 0;
  int unsigned                      quiet_cycles = 0;

  vibrato_modulated_delay_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // 1 - cos(2*pi*k/N) in Q1.15, formed as 2*sin^2(pi*k/N) with quarter-wave folding.
  function automatic logic [vmd_pkg::COS_W-1:0] half_versine_q15(input int unsigned k);
    logic [63:0] fold;
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] poly;
    logic [63:0] sine;
    logic [63:0] sine_sq;
    fold = 64'(k);
    if (2 * fold > 64'(vmd_pkg::COS_ENTRIES)) begin
      fold = 64'(vmd_pkg::COS_ENTRIES) - fold;
    end
    ang    = (PI_IN_Q30 * fold) / 64'(vmd_pkg::COS_ENTRIES);
    ang_sq = (ang * ang) >> 30;
    poly   = ONE_Q30;
    for (int n = 0; n <= 4; n++) begin
      poly = ONE_Q30 - ((ang_sq * poly) >> 30) / 64'(TAYLOR_DIV[n]);
    end
    sine = (ang * poly) >> 30;
    if (sine > ONE_Q30) begin
      sine = ONE_Q30;
    end
    sine_sq = (sine * sine) >> 30;
    return vmd_pkg::COS_W'((sine_sq + 64'd8192) >> 14);
  endfunction

  // Writes the word into the store, then interpolates behind the write pointer.
  function automatic logic signed [vmd_pkg::SMP_W-1:0] predict_sample(
    input logic signed [vmd_pkg::SMP_W-1:0] word
  );
    logic [vmd_pkg::LEN_W-1:0] span;
    logic [vmd_pkg::LEN_W-1:0] whole;
    logic [vmd_pkg::LEN_W-1:0] newer;
    logic [vmd_pkg::LEN_W-1:0] older;
    logic [63:0]               delay;
    logic [63:0]               max_delay;
    longint                    frac;
    longint                    acc;
    span = model_cfg.period_length;
    if (span == 0) begin
      span = vmd_pkg::LEN_W'(1);
    end
    if (span > vmd_pkg::MAX_PERIOD) begin
      span = vmd_pkg::LEN_W'(vmd_pkg::MAX_PERIOD);
    end
    if (write_ptr >= span) begin
      write_ptr = '0;
    end
    delay_copy[write_ptr] = word;
    delay = (64'(model_cfg.depth) * 64'(versine_q15[lfo_acc[31 -: vmd_pkg::COS_AW]])) >> 15;
    max_delay = 64'(span - 1) << vmd_pkg::FRAC_W;
    if (delay > max_delay) begin
      delay = max_delay;
    end
    whole = vmd_pkg::LEN_W'(delay >> vmd_pkg::FRAC_W);
    frac  = longint'(delay[vmd_pkg::FRAC_W-1:0]);
    newer = vmd_pkg::LEN_W'((32'(write_ptr) + 32'(span) - 32'(whole)) % 32'(span));
    older = vmd_pkg::LEN_W'((32'(newer) + 32'(span) - 1) % 32'(span));
    acc = longint'(delay_copy[newer]) * (256 - frac) + longint'(delay_copy[older]) * frac + 128;
    acc = acc >>> 8;
    if (acc > 32767) begin
      acc = 32767;
    end
    if (acc < -32768) begin
      acc = -32768;
    end
    write_ptr = write_ptr + vmd_pkg::LEN_W'(1);
    if (write_ptr >= span) begin
      write_ptr = '0;
    end
    lfo_acc = lfo_acc + model_cfg.phase_step;
    return vmd_pkg::SMP_W'(acc);
  endfunction

  // Sender: predicts each accepted word and offers the next one from the queue.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_samples.push_back(predict_sample(sample_in_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i  <= 1'b1;
          sample_in_i <= pending_words.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: expected no word, got sample_out %0d", $time, sample_out_o);
          mismatch_count++;
        end else begin
          if (sample_out_o !== expected_samples[0]) begin
            $display("%0t: sample_out expected %0d, got %0d", $time, expected_samples[0],
                     sample_out_o);
            mismatch_count++;
          end
          void'(expected_samples.pop_front());
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Judged at the falling edge, once every update of the rising edge has settled.
  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (pending_words.size() != 0 || in_valid_i || expected_samples.size() != 0);
  endtask

  task automatic set_config(
    input logic [vmd_pkg::LEN_W-1:0]   len,
    input logic [vmd_pkg::DEPTH_W-1:0] dep,
    input logic [vmd_pkg::STEP_W-1:0]  step
  );
    logic [1:0]                idx;
    logic [vmd_pkg::APB_DW-1:0] value;
    for (int r = 0; r < 3; r++) begin
      idx = 2'(r);
      case (idx)
        vmd_pkg::REG_PERIOD_LENGTH: value = 32'(len);
        vmd_pkg::REG_DEPTH:         value = 32'(dep);
        vmd_pkg::REG_PHASE_STEP:    value = step;
        default:                    value = '0;
      endcase
      @(posedge clk_i);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clk_i);
      penable <= 1'b1;
      do begin
        @(posedge clk_i);
      end while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
    model_cfg = '{period_length: len, depth: dep, phase_step: step};
  endtask

  initial begin
    logic [vmd_pkg::LEN_W-1:0]   len;
    logic [vmd_pkg::DEPTH_W-1:0] dep;
    logic [vmd_pkg::STEP_W-1:0]  step;
    logic signed [15:0]          word;

    for (int i = 0; i < vmd_pkg::COS_ENTRIES; i++) begin
      versine_q15[i] = half_versine_q15(i);
    end
    for (int i = 0; i < vmd_pkg::MAX_PERIOD; i++) begin
      delay_copy[i] = '0;
    end
    write_ptr = '0;
    lfo_acc   = '0;
    model_cfg = '{period_length: vmd_pkg::PERIOD_RESET, depth: vmd_pkg::DEPTH_RESET,
                  phase_step: vmd_pkg::STEP_RESET};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings with zero depth: each word comes straight back.
    pending_words = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, 16'sh5555, 16'shAAAA};
    wait_drained();
    // A zero period acts as a one-sample store, so the word just written returns.
    set_config(13'd0, 20'hFFFFF, 32'h0);
    pending_words = '{16'sd32767, -16'sd32768, 16'sd12345};
    wait_drained();
    // Over-long period with the delay pushed past the store; the phase wraps.
    set_config(13'd8191, 20'hFFFFF, 32'h8000_0000);
    pending_words = '{16'sd1000, -16'sd2000, 16'sd3000, -16'sd4000, 16'sd5000, -16'sd6000};
    wait_drained();
    // The write pointer now lies beyond the shorter period and must restart.
    set_config(13'd5, 20'd300, 32'hC000_0000);
    pending_words = '{16'sd32767, -16'sd32768, 16'sd7, -16'sd9, 16'sd256};

    for (int k = 0; k < 12; k++) begin
      wait_drained();
      send_idle_pct = (k < 4) ? 30 : ((k < 8) ? 54 : 0);
      recv_idle_pct = (k < 4) ? 54 : ((k < 8) ? 30 : 0);
      case (k % 4)
        0: begin
          len  = 13'($urandom_range(2, 64));
          dep  = 20'($urandom_range(0, 32'(len) * 512));
          step = $urandom;
        end
        1: begin
          len  = 13'($urandom_range(2, vmd_pkg::MAX_PERIOD));
          dep  = 20'($urandom);
          step = 32'((64'd1 << 32) / 64'(len));
        end
        2: begin
          case (k / 4)
            0:       begin len = 13'd2;    dep = 20'hFFFFF; step = 32'hFFFF_FFFF; end
            1:       begin len = 13'd4096; dep = 20'd0;     step = 32'h0;         end
            default: begin len = 13'd8191; dep = 20'hFFFFF; step = 32'h1;         end
          endcase
        end
        default: begin
          len  = 13'($urandom);
          dep  = 20'($urandom);
          step = $urandom;
        end
      endcase
      set_config(len, dep, step);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        case ($urandom_range(9))
          0:       word = -16'sd32768;
          1:       word = 16'sd32767;
          default: word = 16'($urandom);
        endcase
        pending_words.push_back(word);
      end
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && expected_samples.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
